### rtl/core/nsd_pkg.sv
// shared types, constants and helpers for the spoken digit token builder
package nsd_pkg;

  // prompt buffer depth in words
  localparam int BUFFER_DEPTH = 64;

  // field widths
  localparam int NUM_W      = 32;
  localparam int FILL_W     = 7;
  localparam int CODE_W     = 6;
  localparam int SLOT_IDX_W = 6;

  // running slot counter: holds any fill level plus the emitted words
  localparam int DEPTH_BITS = $clog2(BUFFER_DEPTH + 1);
  localparam int SLOT_W     = ((DEPTH_BITS > FILL_W) ? DEPTH_BITS : FILL_W) + 1;

  // decimal conversion
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int POS_W      = $clog2(BCD_DIGITS);
  localparam int CONV_STEPS = NUM_W;
  localparam int CNT_W      = $clog2(CONV_STEPS);

  // word codes
  localparam logic [CODE_W-1:0] PAUSE_LEN   = CODE_W'(5);
  localparam logic [CODE_W-1:0] MARKER_CLIP = CODE_W'(37);
  localparam logic [CODE_W-1:0] ZERO_CLIP   = CODE_W'(0);
  localparam logic [NUM_W-1:0]  MOST_NEG    = 32'h8000_0000;

  // clip base for each place inside a group of four digits
  function automatic logic [CODE_W-1:0] place_base(input logic [1:0] place);
    logic [CODE_W-1:0] base;
    case (place)
      2'd0:    base = CODE_W'(0);
      2'd1:    base = CODE_W'(9);
      2'd2:    base = CODE_W'(18);
      default: base = CODE_W'(27);
    endcase
    return base;
  endfunction

  // result of the binary to decimal converter
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } conv_res_t;

  // start request for the word sequencer
  typedef struct packed {
    logic              start;
    logic [BCD_W-1:0]  bcd;
    logic [FILL_W-1:0] fill;
  } seq_start_t;

endpackage

### rtl/core/number_to_spoken_digit_tokens.sv
// top level of the spoken digit token builder
// A number is taken while in_ready is high; its magnitude is first converted
// to ten decimal digits by a shift-and-add-three unit that takes one bit per
// cycle, then a sequencer walks the digits from the least significant one,
// emitting the words of each digit, and releases the final word tagged with
// out_last_word, after which in_ready returns. The sequencer waits while
// out_ready is low and the output register already holds a word. The most
// negative number produces no words and leaves in_ready high. Words whose
// slot reaches the buffer depth are dropped. The last word of one number may
// still wait in the output register while the next number is taken.
module number_to_spoken_digit_tokens (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [nsd_pkg::NUM_W-1:0] in_number_in,
  input  logic [nsd_pkg::FILL_W-1:0]      in_fill_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_is_voice,
  output logic [nsd_pkg::CODE_W-1:0]      out_word_code,
  output logic [nsd_pkg::SLOT_IDX_W-1:0]  out_slot_index,
  output logic                            out_last_word
);

  typedef enum logic [1:0] {T_IDLE, T_CONV, T_SPEAK} state_t;

  state_t                      state_r, state_nxt;
  logic [nsd_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic                        in_xfer;
  logic                        conv_start;
  logic [nsd_pkg::NUM_W-1:0]   raw;
  logic [nsd_pkg::NUM_W-1:0]   mag;
  nsd_pkg::conv_res_t          conv_res;
  nsd_pkg::seq_start_t         seq_req;
  logic                        seq_done;

  assign in_ready = (state_r == T_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign raw      = in_number_in;
  assign mag      = raw[nsd_pkg::NUM_W-1] ? (~raw + 1'b1) : raw;
  // the most negative value speaks nothing
  assign conv_start = in_xfer && (raw != nsd_pkg::MOST_NEG);

  // item sequencing: convert, then speak
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    unique case (state_r)
      T_IDLE: begin
        if (conv_start) begin
          fill_nxt  = in_fill_level;
          state_nxt = T_CONV;
        end
      end
      T_CONV:  if (conv_res.done) state_nxt = T_SPEAK;
      T_SPEAK: if (seq_done) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    fill_r <= fill_nxt;
  end

  assign seq_req.start = (state_r == T_CONV) && conv_res.done;
  assign seq_req.bcd   = conv_res.bcd;
  assign seq_req.fill  = fill_r;

  nsd_bin2bcd u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .mag   (mag),
    .res   (conv_res)
  );

  nsd_word_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (seq_req),
    .done           (seq_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_voice   (out_is_voice),
    .out_word_code  (out_word_code),
    .out_slot_index (out_slot_index),
    .out_last_word  (out_last_word)
  );

endmodule

### rtl/core/nsd_bin2bcd.sv
// shift-and-add-three converter from binary magnitude to packed decimal digits
module nsd_bin2bcd (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [nsd_pkg::NUM_W-1:0] mag,
  output nsd_pkg::conv_res_t       res
);

  logic [nsd_pkg::NUM_W-1:0] bin_r, bin_nxt;
  logic [nsd_pkg::BCD_W-1:0] bcd_r, bcd_nxt;
  logic [nsd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [nsd_pkg::BCD_W-1:0] adj;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < nsd_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  // one shift per cycle
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[nsd_pkg::BCD_W-2:0], bin_r[nsd_pkg::NUM_W-1]};
      bin_nxt = {bin_r[nsd_pkg::NUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == nsd_pkg::CNT_W'(nsd_pkg::CONV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign res.done = done_r;
  assign res.bcd  = bcd_r;

endmodule

### rtl/core/nsd_word_seq.sv
// digit walker that turns decimal digits into pause and clip words
module nsd_word_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nsd_pkg::seq_start_t            req,
  output logic                           done,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_voice,
  output logic [nsd_pkg::CODE_W-1:0]     out_word_code,
  output logic [nsd_pkg::SLOT_IDX_W-1:0] out_slot_index,
  output logic                           out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_ZERO, S_DIGIT, S_PAUSE, S_VOICE, S_MARK, S_FLUSH
  } state_t;

  state_t                            state_r, state_nxt;
  logic [nsd_pkg::BCD_W-1:0]         bcd_r, bcd_nxt;
  logic [nsd_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic [nsd_pkg::SLOT_W-1:0]        slot_r, slot_nxt;
  logic                              done_r, done_nxt;
  // one word held back so the final word can be tagged
  logic                              pend_valid_r, pend_valid_nxt;
  logic                              pend_voice_r, pend_voice_nxt;
  logic [nsd_pkg::CODE_W-1:0]        pend_code_r, pend_code_nxt;
  logic [nsd_pkg::SLOT_IDX_W-1:0]    pend_slot_r, pend_slot_nxt;
  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_voice_r, out_voice_nxt;
  logic [nsd_pkg::CODE_W-1:0]        out_code_r, out_code_nxt;
  logic [nsd_pkg::SLOT_IDX_W-1:0]    out_slot_r, out_slot_nxt;
  logic                              out_last_r, out_last_nxt;

  logic [3:0]                 digit;
  logic                       rest;
  logic                       room;
  logic                       out_free;
  logic                       can_emit;
  logic                       emit_state;
  logic                       w_voice;
  logic [nsd_pkg::CODE_W-1:0] w_code;
  logic                       step;
  state_t                     post_state;
  logic                       post_adv;

  assign digit    = bcd_r[3:0];
  assign rest     = |bcd_r[nsd_pkg::BCD_W-1:4];
  assign room     = slot_r < nsd_pkg::SLOT_W'(nsd_pkg::BUFFER_DEPTH);
  assign out_free = !out_valid_r || out_ready;
  assign can_emit = !pend_valid_r || out_free;

  // word of the current emitting state
  always_comb begin
    emit_state = 1'b1;
    w_voice    = 1'b1;
    w_code     = nsd_pkg::ZERO_CLIP;
    unique case (state_r)
      S_ZERO:  w_code = nsd_pkg::ZERO_CLIP;
      S_PAUSE: begin
        w_voice = 1'b0;
        w_code  = nsd_pkg::PAUSE_LEN;
      end
      S_VOICE: w_code = nsd_pkg::place_base(pos_r[1:0]) + nsd_pkg::CODE_W'(digit);
      S_MARK:  w_code = nsd_pkg::MARKER_CLIP;
      default: emit_state = 1'b0;
    endcase
  end

  // words past the buffer end are dropped without waiting
  assign step = emit_state && (!room || can_emit);

  // what follows a digit: marker after the fourth digit, next digit or finish
  always_comb begin
    post_adv = 1'b0;
    if (rest && pos_r == nsd_pkg::POS_W'(3)) begin
      post_state = S_MARK;
    end else if (rest) begin
      post_state = S_DIGIT;
      post_adv   = 1'b1;
    end else begin
      post_state = S_FLUSH;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    bcd_nxt        = bcd_r;
    pos_nxt        = pos_r;
    slot_nxt       = slot_r;
    done_nxt       = 1'b0;
    pend_valid_nxt = pend_valid_r;
    pend_voice_nxt = pend_voice_r;
    pend_code_nxt  = pend_code_r;
    pend_slot_nxt  = pend_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_voice_nxt  = out_voice_r;
    out_code_nxt   = out_code_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;

    // store a word: older held word moves to the output register
    if (step && room) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_voice_nxt = pend_voice_r;
        out_code_nxt  = pend_code_r;
        out_slot_nxt  = pend_slot_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_voice_nxt = w_voice;
      pend_code_nxt  = w_code;
      pend_slot_nxt  = slot_r[nsd_pkg::SLOT_IDX_W-1:0];
      slot_nxt       = slot_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          bcd_nxt   = req.bcd;
          pos_nxt   = '0;
          slot_nxt  = nsd_pkg::SLOT_W'(req.fill);
          state_nxt = (req.bcd == '0) ? S_ZERO : S_DIGIT;
        end
      end
      S_ZERO: begin
        if (step) state_nxt = S_FLUSH;
      end
      S_DIGIT: begin
        if (digit != 4'd0) begin
          state_nxt = (pos_r[1:0] != 2'd0) ? S_PAUSE : S_VOICE;
        end else begin
          state_nxt = post_state;
          if (post_adv) begin
            bcd_nxt = bcd_r >> 4;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      S_PAUSE: begin
        if (step) state_nxt = S_VOICE;
      end
      S_VOICE: begin
        if (step) begin
          state_nxt = post_state;
          if (post_adv) begin
            bcd_nxt = bcd_r >> 4;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      S_MARK: begin
        if (step) begin
          state_nxt = S_DIGIT;
          bcd_nxt   = bcd_r >> 4;
          pos_nxt   = pos_r + 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_voice_nxt  = pend_voice_r;
          out_code_nxt   = pend_code_r;
          out_slot_nxt   = pend_slot_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
          done_nxt       = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      done_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      done_r       <= done_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    bcd_r        <= bcd_nxt;
    pos_r        <= pos_nxt;
    slot_r       <= slot_nxt;
    pend_voice_r <= pend_voice_nxt;
    pend_code_r  <= pend_code_nxt;
    pend_slot_r  <= pend_slot_nxt;
    out_voice_r  <= out_voice_nxt;
    out_code_r   <= out_code_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign done           = done_r;
  assign out_valid      = out_valid_r;
  assign out_is_voice   = out_voice_r;
  assign out_word_code  = out_code_r;
  assign out_slot_index = out_slot_r;
  assign out_last_word  = out_last_r;

endmodule

### rtl/core/nsd_checker.sv
// port-level checks for the spoken digit token builder, bound to the top level
module nsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [nsd_pkg::NUM_W-1:0]      in_number_in,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_is_voice,
  input logic [nsd_pkg::CODE_W-1:0]     out_word_code
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn before transfer");

  // a number that speaks keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_number_in != nsd_pkg::MOST_NEG |=> !in_ready)
    else $error("ready right after taking a number");

  // pause words always carry the pause length
  a_pause_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_voice |-> out_word_code == nsd_pkg::PAUSE_LEN)
    else $error("pause word with wrong length");

  // voice clip codes never exceed the marker clip
  a_clip_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_voice |-> out_word_code <= nsd_pkg::MARKER_CLIP)
    else $error("voice clip code out of range");

endmodule

bind number_to_spoken_digit_tokens nsd_checker u_nsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_number_in  (in_number_in),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_is_voice  (out_is_voice),
  .out_word_code (out_word_code)
);
